// File: hdl/stq_pkg.sv
package stq_pkg;

	localparam int QUEUE_DEPTH  = 32;
	localparam int TIME_BITS    = 32;
	localparam int HANDLER_BITS = 8;
	localparam int ARG_BITS     = 16;
	localparam int MIN_DELAY_RESET = 100;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_INSERT    = 2'd0,
		MODE_POP       = 2'd1,
		MODE_CANCEL_H  = 2'd2,
		MODE_CANCEL_HA = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]    due;
		logic [HANDLER_BITS-1:0] handler;
		logic [ARG_BITS-1:0]     arg;
		logic                    live;
	} entry_t;

	// Slot of the entry at a given offset from the head of the ring.
	function automatic logic [IDX_W-1:0] ring_ptr(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// File: hdl/sorted_timer_alarm_queue.sv
// Sorted alarm queue, held as a ring in a single memory of QUEUE_DEPTH entries.
// Input channel (in_valid/in_ready) takes one command beat: insert, pop head,
// cancel by handler, or cancel by handler and argument. Every command gives
// exactly one result beat on the output channel (out_valid/out_ready).
// The configuration port writes min_delay whenever min_delay_we is high.
// The memory is walked one entry at a time before out_valid rises:
//   insert: scan until the slot, shift the tail back, write the new entry,
//   pop: read and remove the head entry, cancel: read each entry held and
//   clear the matching ones, full insert or empty pop: no memory access.
// in_ready is high only while no command is in progress; one command runs at
// a time. The result sits in an output register, so the next command can be
// taken while a result waits. If the receiver stalls with a result still held,
// the following command finishes its work and then waits until that beat is
// taken before it loads its own result.
// Reset empties the queue and sets min_delay to 100. The memory contents are
// not cleared; only entries below the fill count are ever used.
module sorted_timer_alarm_queue
	import stq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    min_delay_we,
	input  logic [TIME_BITS-1:0]    min_delay,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [TIME_BITS-1:0]    now_time,
	input  logic [TIME_BITS-1:0]    delay,
	input  logic [HANDLER_BITS-1:0] handler_id,
	input  logic [ARG_BITS-1:0]     handler_arg,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    fired,
	output logic [HANDLER_BITS-1:0] fired_handler,
	output logic [ARG_BITS-1:0]     fired_arg,
	output logic                    fired_live,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        entry_count,
	output logic                    head_valid,
	output logic [TIME_BITS-1:0]    head_time
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_CALC     = 14'b00000000000010,
		S_SCAN_RD  = 14'b00000000000100,
		S_SCAN_CMP = 14'b00000000001000,
		S_SH_RD    = 14'b00000000010000,
		S_SH_WR    = 14'b00000000100000,
		S_WRITE    = 14'b00000001000000,
		S_POP_RD   = 14'b00000010000000,
		S_POP_CAP  = 14'b00000100000000,
		S_CAN_RD   = 14'b00001000000000,
		S_CAN_WR   = 14'b00010000000000,
		S_HEAD_RD  = 14'b00100000000000,
		S_HEAD_CAP = 14'b01000000000000,
		S_DONE     = 14'b10000000000000
	} state_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic [TIME_BITS-1:0]    min_delay_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [TIME_BITS-1:0]    due_q;
	logic [HANDLER_BITS-1:0] hid_q;
	logic [ARG_BITS-1:0]     harg_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        k_q;
	logic [CNT_W-1:0]        pos_q;

	logic                    fired_q;
	logic [HANDLER_BITS-1:0] fh_q;
	logic [ARG_BITS-1:0]     fa_q;
	logic                    flive_q;
	status_t                 status_q;
	logic [TIME_BITS-1:0]    htime_q;

	logic                    ovalid_q;
	logic                    ofired_q;
	logic [HANDLER_BITS-1:0] ofh_q;
	logic [ARG_BITS-1:0]     ofa_q;
	logic                    oflive_q;
	status_t                 ostatus_q;
	logic [CNT_W-1:0]        ocnt_q;
	logic [TIME_BITS-1:0]    ohtime_q;

	entry_t                  mem_q [QUEUE_DEPTH];
	entry_t                  rdata_q;
	logic [IDX_W-1:0]        raddr;
	logic                    mem_we;
	logic [IDX_W-1:0]        waddr;
	entry_t                  wdata;

	logic                    accept;
	logic                    load_res;
	logic [TIME_BITS:0]      due_sum;
	logic                    cancel_hit;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_res = (state_q == S_DONE) && (!ovalid_q || out_ready);
	assign due_sum  = {1'b0, now_q} + {1'b0, due_q};

	assign cancel_hit = rdata_q.live && (rdata_q.handler == hid_q) &&
		((mode_q != MODE_CANCEL_HA) || (rdata_q.arg == harg_q));

	always_comb begin
		raddr  = head_q;
		mem_we = 1'b0;
		waddr  = ring_ptr(head_q, k_q);
		wdata  = rdata_q;
		unique case (state_q)
			S_SCAN_RD: raddr = ring_ptr(head_q, k_q);
			S_SH_RD:   raddr = ring_ptr(head_q, k_q - 1'b1);
			S_SH_WR:   mem_we = 1'b1;
			S_WRITE: begin
				mem_we = 1'b1;
				waddr  = ring_ptr(head_q, pos_q);
				wdata  = '{due: due_q, handler: hid_q, arg: harg_q, live: 1'b1};
			end
			S_CAN_RD: raddr = ring_ptr(head_q, k_q);
			S_CAN_WR: begin
				mem_we     = cancel_hit;
				wdata.live = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= TIME_BITS'(MIN_DELAY_RESET);
		end else if (min_delay_we) begin
			min_delay_q <= min_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			htime_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= mode_t'(mode);
						now_q    <= now_time;
						hid_q    <= handler_id;
						harg_q   <= handler_arg;
						k_q      <= '0;
						fired_q  <= 1'b0;
						fh_q     <= '0;
						fa_q     <= '0;
						flive_q  <= 1'b0;
						status_q <= STATUS_OK;
						due_q    <= (delay < min_delay_q) ? min_delay_q : delay;
						unique case (mode_t'(mode))
							MODE_INSERT: begin
								if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
									status_q <= STATUS_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_CALC;
								end
							end
							MODE_POP: begin
								if (cnt_q == '0) begin
									status_q <= STATUS_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_POP_RD;
								end
							end
							MODE_CANCEL_H, MODE_CANCEL_HA: state_q <= S_CAN_RD;
						endcase
					end
				end
				S_CALC: begin
					// Saturate at the top of the time range on carry out.
					due_q   <= due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (k_q == cnt_q) begin
						pos_q   <= k_q;
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					// Equal due times keep arrival order, so the new entry goes after them.
					if (rdata_q.due <= due_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						pos_q   <= k_q;
						k_q     <= cnt_q;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					state_q <= (k_q == pos_q) ? S_WRITE : S_SH_WR;
				end
				S_SH_WR: begin
					k_q     <= k_q - 1'b1;
					state_q <= S_SH_RD;
				end
				S_WRITE: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_HEAD_RD;
				end
				S_POP_RD: state_q <= S_POP_CAP;
				S_POP_CAP: begin
					fired_q <= 1'b1;
					fh_q    <= rdata_q.handler;
					fa_q    <= rdata_q.arg;
					flive_q <= rdata_q.live;
					head_q  <= ring_ptr(head_q, CNT_W'(1));
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_HEAD_RD;
				end
				S_CAN_RD: begin
					state_q <= (k_q == cnt_q) ? S_DONE : S_CAN_WR;
				end
				S_CAN_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_CAN_RD;
				end
				S_HEAD_RD: begin
					if (cnt_q == '0) begin
						htime_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_HEAD_CAP;
					end
				end
				S_HEAD_CAP: begin
					htime_q <= rdata_q.due;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_res) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_res) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			ofired_q  <= fired_q;
			ofh_q     <= fh_q;
			ofa_q     <= fa_q;
			oflive_q  <= flive_q;
			ostatus_q <= status_q;
			ocnt_q    <= cnt_q;
			ohtime_q  <= htime_q;
		end
	end

	assign out_valid     = ovalid_q;
	assign fired         = ofired_q;
	assign fired_handler = ofh_q;
	assign fired_arg     = ofa_q;
	assign fired_live    = oflive_q;
	assign status        = ostatus_q;
	assign entry_count   = ocnt_q;
	assign head_valid    = (ocnt_q != '0);
	assign head_time     = ohtime_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("command accepted while another is in progress");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load_res && status_q == STATUS_FULL) |-> cnt_q == CNT_W'(QUEUE_DEPTH))
		else $error("full status with room left");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(load_res && fired_q) |-> (status_q == STATUS_OK && mode_q == MODE_POP))
		else $error("fired result outside a successful pop");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(load_res && cnt_q == '0) |-> htime_q == '0)
		else $error("head time not cleared on empty queue");

endmodule
